>>> src/hset_pkg.sv
// Shared types, constants and codes for the chained hash set.
package hset_pkg;

  localparam int unsigned MaxBucketsDefault = 4096;
  localparam int unsigned PoolDepthDefault  = 4096;

  localparam int unsigned KeyW      = 63;
  localparam int unsigned RegW      = 13;
  localparam int unsigned CountW    = 13;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned DivCntW   = 6;
  localparam int unsigned RemW      = RegW + 1;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  localparam logic [RegW-1:0] BucketCountReset = 13'd4093;
  localparam logic [RegW-1:0] CapacityReset    = 13'd4096;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_DUP  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd2;

  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_CAPACITY     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_HEAD_CHK,
    ST_ENT_CHK,
    ST_RESULT
  } hset_state_e;

  typedef struct packed {
    logic               clr_step;
    logic               load;
    logic               div_step;
    logic               claim;
    logic               head_rd;
    logic               head_set;
    logic               ent_rd_head;
    logic               ent_rd_link;
    logic               link_set;
    logic               res_set;
    logic               res_found;
    logic [StatusW-1:0] res_status;
    logic               res_load;
  } hset_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_lookup;
    logic full;
    logic head_valid;
    logic key_match;
    logic link_valid;
    logic out_free;
  } hset_sts_t;

endpackage

>>> src/hset_if.sv
// Stream interfaces for input items and result beats.
interface hset_in_if;
  import hset_pkg::*;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [KeyW-1:0] key;
  modport source (output valid, operation, key, input ready);
  modport sink (input valid, operation, key, output ready);
endinterface

interface hset_out_if;
  import hset_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  entry_count;
  modport source (output valid, found, status, entry_count, input ready);
  modport sink (input valid, found, status, entry_count, output ready);
endinterface

>>> src/hset_ctrl.sv
// Controller state machine sequencing modulo, chain walk and result.
module hset_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hset_pkg::hset_sts_t sts_i,
  output hset_pkg::hset_cmd_t cmd_o
);
  import hset_pkg::*;

  hset_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          if (!sts_i.is_lookup && sts_i.full) state_d = ST_RESULT;
          else state_d = ST_HEAD_CHK;
        end
      end
      ST_HEAD_CHK: begin
        if (!sts_i.head_valid) state_d = ST_RESULT;
        else state_d = ST_ENT_CHK;
      end
      ST_ENT_CHK: begin
        if (sts_i.key_match || !sts_i.link_valid) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (!sts_i.is_lookup && sts_i.full) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = STATUS_FULL;
        end else begin
          cmd_o.head_rd = 1'b1;
          cmd_o.claim   = !sts_i.is_lookup;
        end
      end
      ST_HEAD_CHK: begin
        if (!sts_i.head_valid) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.head_set = !sts_i.is_lookup;
        end else begin
          cmd_o.ent_rd_head = 1'b1;
        end
      end
      ST_ENT_CHK: begin
        if (sts_i.key_match) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_found  = 1'b1;
          cmd_o.res_status = sts_i.is_lookup ? STATUS_OK : STATUS_DUP;
        end else if (!sts_i.link_valid) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.link_set = !sts_i.is_lookup;
        end else begin
          cmd_o.ent_rd_link = 1'b1;
        end
      end
      ST_RESULT: cmd_o.res_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> src/hset_dp.sv
// Datapath: modulo divider, bucket head and entry memories, result register.
module hset_dp #(
  parameter int unsigned MAX_BUCKETS = hset_pkg::MaxBucketsDefault,
  parameter int unsigned POOL_DEPTH  = hset_pkg::PoolDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hset_pkg::hset_cmd_t           cmd_i,
  output hset_pkg::hset_sts_t           sts_o,
  input  logic                          operation_i,
  input  logic [hset_pkg::KeyW-1:0]     key_i,
  input  logic [hset_pkg::RegW-1:0]     bucket_count_i,
  input  logic [hset_pkg::RegW-1:0]     capacity_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [hset_pkg::StatusW-1:0]  status_o,
  output logic [hset_pkg::CountW-1:0]   entry_count_o
);
  import hset_pkg::*;

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  logic [PW:0]     head_mem [MAX_BUCKETS];
  logic [KeyW-1:0] key_mem  [POOL_DEPTH];
  logic [PW:0]     link_mem [POOL_DEPTH];

  logic [BW-1:0]      clr_cnt_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [KeyW-1:0]    shr_q, key_q;
  logic [RemW-1:0]    rem_q, rem_t;
  logic               op_q;
  logic [CW-1:0]      used_q;
  logic [PW-1:0]      slot_q, cur_q, ent_addr;
  logic [PW:0]        head_rd_q, link_rd_q;
  logic [KeyW-1:0]    key_rd_q;
  logic [RegW-1:0]    divisor;
  logic [31:0]        eff_cap;
  logic [BW-1:0]      bkt;
  logic               res_found_q, out_valid_q;
  logic [StatusW-1:0] res_status_q;

  always_comb begin
    if (bucket_count_i == '0) divisor = RegW'(1);
    else if (32'(bucket_count_i) > MAX_BUCKETS) divisor = RegW'(MAX_BUCKETS);
    else divisor = bucket_count_i;
    eff_cap = (32'(capacity_i) > POOL_DEPTH) ? 32'(POOL_DEPTH) : 32'(capacity_i);
    rem_t   = {rem_q[RemW-2:0], shr_q[KeyW-1]};
    bkt     = BW'(rem_q);
    ent_addr = cmd_i.ent_rd_head ? head_rd_q[PW-1:0] : link_rd_q[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.load) div_cnt_q <= DivCntW'(KeyW);
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q - 1'b1;
      if (cmd_i.claim) used_q <= used_q + 1'b1;
      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      shr_q <= key_i;
      op_q  <= operation_i;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      shr_q <= {shr_q[KeyW-2:0], 1'b0};
      rem_q <= (rem_t >= RemW'(divisor)) ? rem_t - RemW'(divisor) : rem_t;
    end
    if (cmd_i.claim) slot_q <= PW'(used_q);
    if (cmd_i.res_set) begin
      res_found_q  <= cmd_i.res_found;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.res_load) begin
      found_o       <= res_found_q;
      status_o      <= res_status_q;
      entry_count_o <= CountW'(used_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) head_mem[clr_cnt_q] <= '0;
    else if (cmd_i.head_set) head_mem[bkt] <= {1'b1, slot_q};
    if (cmd_i.head_rd) head_rd_q <= head_mem[bkt];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) begin
      key_mem[PW'(used_q)]  <= key_q;
      link_mem[PW'(used_q)] <= '0;
    end else if (cmd_i.link_set) begin
      link_mem[cur_q] <= {1'b1, slot_q};
    end
    if (cmd_i.ent_rd_head || cmd_i.ent_rd_link) begin
      cur_q     <= ent_addr;
      key_rd_q  <= key_mem[ent_addr];
      link_rd_q <= link_mem[ent_addr];
    end
  end

  always_comb begin
    sts_o.clr_done   = (clr_cnt_q == BW'(MAX_BUCKETS - 1));
    sts_o.div_done   = (div_cnt_q == '0);
    sts_o.is_lookup  = (op_q == OP_LOOKUP);
    sts_o.full       = (32'(used_q) >= eff_cap);
    sts_o.head_valid = head_rd_q[PW];
    sts_o.key_match  = (key_rd_q == key_q);
    sts_o.link_valid = link_rd_q[PW];
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/chained_hash_set_of_numbers_top.sv
// Top level: configuration registers, controller and datapath of the hash set.
// One item at a time. An accepted item goes through the bit-serial modulo
// by the bucket count (63 shift steps, then a read of the bucket head), a
// check of the head, a check of each chain entry visited, and the load of
// the result register. An insert into a full pool skips the head read and
// the walk and goes straight to its result. After the result register
// loads, the block returns to idle and takes the next item. A stalled
// result holds the controller only when the previous result still waits.
// After reset the bucket head memory is cleared one bucket per cycle
// before the first item is accepted. The result register lets the next
// item enter while a result waits. Registers: bucket_count at 0x0,
// capacity at 0x4.
module chained_hash_set_of_numbers_top #(
  parameter int unsigned MAX_BUCKETS = hset_pkg::MaxBucketsDefault,
  parameter int unsigned POOL_DEPTH  = hset_pkg::PoolDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hset_in_if.sink                        in_i,
  hset_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hset_pkg::ApbAddrW-1:0]  paddr,
  input  logic [hset_pkg::ApbDataW-1:0]  pwdata,
  output logic [hset_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import hset_pkg::*;

  logic [RegW-1:0] bucket_count_q, capacity_q;
  hset_cmd_t       cmd;
  hset_sts_t       sts;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BucketCountReset;
      capacity_q     <= CapacityReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BUCKET_COUNT: bucket_count_q <= pwdata[RegW-1:0];
        REG_CAPACITY:     capacity_q     <= pwdata[RegW-1:0];
        default:          bucket_count_q <= bucket_count_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUCKET_COUNT: prdata = ApbDataW'(bucket_count_q);
      REG_CAPACITY:     prdata = ApbDataW'(capacity_q);
      default:          prdata = '0;
    endcase
  end

  hset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hset_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (in_i.operation),
    .key_i          (in_i.key),
    .bucket_count_i (bucket_count_q),
    .capacity_i     (capacity_q),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .found_o        (out_o.found),
    .status_o       (out_o.status),
    .entry_count_o  (out_o.entry_count)
  );

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == STATUS_FULL |-> !out_o.found)
    else $error("pool full result reports found");

  a_dup_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == STATUS_DUP |-> out_o.found)
    else $error("duplicate result without found");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in progress");

endmodule
